>>> src/dfa_longest_match_core_macros.svh
// Assertion macros shared by the longest-match DFA core.
`ifndef DFA_LONGEST_MATCH_CORE_MACROS_SVH
`define DFA_LONGEST_MATCH_CORE_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define DFA_LM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DFA_LM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dfa_lm_pkg.sv
// Types and constants of the longest-match DFA core.
package dfa_lm_pkg;

  // Default table sizes
  localparam int NUM_STATES_DEF  = 256;
  localparam int TRANS_DEPTH_DEF = 4096;

  // Text limit, capped so that a length fits its 16-bit field
  localparam longint unsigned MAX_TEXT = 64'd65535;
  localparam logic [15:0] TEXT_LIMIT =
    16'((MAX_TEXT < 64'd65535) ? MAX_TEXT : 64'd65535);

  // Stream widths
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // Input item kinds
  typedef enum logic [1:0] {
    ACT_LOAD_STATE = 2'd0,
    ACT_LOAD_TRANS = 2'd1,
    ACT_TEXT       = 2'd2,
    ACT_END        = 2'd3
  } action_e;

  // Walk sequencer
  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_TRANS = 1'b1
  } walk_st_e;

  // Input fields in tdata order, lowest bits last
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        target_none;
    logic [7:0]  target_state;
    logic [11:0] delta_base;
    logic [7:0]  highest_byte;
    logic [7:0]  lowest_byte;
    logic        accepts;
    logic [11:0] entry_index;
  } in_item_t;

  localparam int ITEM_W = $bits(in_item_t);

  // One state table entry
  typedef struct packed {
    logic [11:0] base;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        accept;
  } state_entry_t;

  // One transition word
  typedef struct packed {
    logic       none;
    logic [7:0] target;
  } trans_word_t;

  // One result item
  typedef struct packed {
    logic        text_too_long;
    logic [15:0] match_length;
    logic        match_found;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

>>> src/dfa_lm_walk.sv
// Table memories and byte walk sequencer of the longest-match DFA core.
`include "dfa_longest_match_core_macros.svh"

module dfa_lm_walk import dfa_lm_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int TRANS_DEPTH = TRANS_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  action_e  in_action_i,
  input  in_item_t in_item_i,
  input  logic     out_space_i,
  output logic     res_push_o,
  output result_t  res_o
);

  localparam int SAW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int TAW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;

  // Memories
  state_entry_t state_mem [NUM_STATES];
  trans_word_t  trans_mem [TRANS_DEPTH];

  walk_st_e     st_q, st_d;
  logic [7:0]   active_q, active_d;
  logic         stopped_q, stopped_d;
  logic [15:0]  bytes_q, bytes_d;
  logic [15:0]  best_len_q, best_len_d;
  logic         best_valid_q, best_valid_d;
  logic         ovf_q, ovf_d;
  state_entry_t cache_q, cache_d;
  logic         cache_valid_q, cache_valid_d;
  logic         from_mem_q, from_mem_d;
  logic         acc_pend_q, acc_pend_d;

  state_entry_t st_rd_q;
  trans_word_t  tr_rd_q;
  logic         st_re, st_we, tr_re, tr_we;
  logic [SAW-1:0] st_raddr, st_waddr;
  logic [TAW-1:0] tr_raddr, tr_waddr;
  state_entry_t st_wdata;
  trans_word_t  tr_wdata;

  state_entry_t entry;
  logic         cache_ok;
  logic         fire;
  logic         bv_eff;
  logic [15:0]  bl_eff;
  logic [12:0]  tidx;
  logic [SAW+7:0]  act_ext, tgt_ext;
  logic [SAW+11:0] sidx_ext;
  logic [TAW+12:0] tidx_ext;
  logic [TAW+11:0] widx_ext;
  logic         end_found;
  logic [15:0]  end_len;

  // Address forming: zero-extend, then keep the bits the depth needs
  assign act_ext  = {{SAW{1'b0}}, active_q};
  assign tgt_ext  = {{SAW{1'b0}}, tr_rd_q.target};
  assign sidx_ext = {{SAW{1'b0}}, in_item_i.entry_index};
  assign widx_ext = {{TAW{1'b0}}, in_item_i.entry_index};
  assign tidx     = {1'b0, entry.base} + {5'd0, in_item_i.text_byte};
  assign tidx_ext = {{TAW{1'b0}}, tidx};

  assign st_waddr = sidx_ext[SAW-1:0];
  assign tr_waddr = widx_ext[TAW-1:0];
  assign st_wdata = '{base:   in_item_i.delta_base,
                      hi:     in_item_i.highest_byte,
                      lo:     in_item_i.lowest_byte,
                      accept: in_item_i.accepts};
  assign tr_wdata = '{none: in_item_i.target_none, target: in_item_i.target_state};

  // State entry of the active state: fresh read data or the cached copy
  assign entry    = from_mem_q ? st_rd_q : cache_q;
  assign cache_ok = cache_valid_q | from_mem_q;

  assign in_ready_o = (st_q == ST_RUN) && cache_ok && out_space_i;
  assign fire       = in_valid_i && in_ready_o;

  // Accept check of the state reached by the previous byte
  assign bv_eff = best_valid_q | (acc_pend_q & st_rd_q.accept);
  assign bl_eff = (acc_pend_q & st_rd_q.accept) ? bytes_q : best_len_q;

  // End item result: a recorded match, else the empty prefix
  assign end_found = bv_eff | ((bytes_q == 16'd0) && !stopped_q && entry.accept);
  assign end_len   = bv_eff ? bl_eff : 16'd0;

  // Next state and memory requests
  always_comb begin
    st_d          = st_q;
    active_d      = active_q;
    stopped_d     = stopped_q;
    bytes_d       = bytes_q;
    best_len_d    = bl_eff;
    best_valid_d  = bv_eff;
    ovf_d         = ovf_q;
    cache_d       = from_mem_q ? st_rd_q : cache_q;
    cache_valid_d = cache_valid_q | from_mem_q;
    from_mem_d    = 1'b0;
    acc_pend_d    = 1'b0;
    st_re         = 1'b0;
    st_raddr      = act_ext[SAW-1:0];
    tr_re         = 1'b0;
    tr_raddr      = tidx_ext[TAW-1:0];
    st_we         = 1'b0;
    tr_we         = 1'b0;
    res_push_o    = 1'b0;
    res_o         = '{text_too_long: ovf_q, match_length: end_len,
                      match_found: end_found};
    case (st_q)
      ST_RUN: begin
        if (!cache_ok) begin
          // refetch the active state's entry
          st_re      = 1'b1;
          from_mem_d = 1'b1;
        end else if (fire) begin
          case (in_action_i)
            ACT_LOAD_STATE: begin
              if (32'(in_item_i.entry_index) < 32'(NUM_STATES)) begin
                st_we = 1'b1;
                if (in_item_i.entry_index == {4'd0, active_q}) begin
                  cache_d       = st_wdata;
                  cache_valid_d = 1'b1;
                end
              end
            end
            ACT_LOAD_TRANS: begin
              if (32'(in_item_i.entry_index) < 32'(TRANS_DEPTH)) begin
                tr_we = 1'b1;
              end
            end
            ACT_TEXT: begin
              if (bytes_q >= TEXT_LIMIT) begin
                ovf_d = 1'b1;
              end else begin
                if ((bytes_q == 16'd0) && !stopped_q && entry.accept) begin
                  best_valid_d = 1'b1;
                  best_len_d   = 16'd0;
                end
                bytes_d = bytes_q + 16'd1;
                if (!stopped_q) begin
                  if ((in_item_i.text_byte < entry.lo) ||
                      (in_item_i.text_byte > entry.hi)) begin
                    stopped_d = 1'b1;
                  end else if (32'(tidx) >= 32'(TRANS_DEPTH)) begin
                    stopped_d = 1'b1;
                  end else begin
                    tr_re = 1'b1;
                    st_d  = ST_TRANS;
                  end
                end
              end
            end
            ACT_END: begin
              res_push_o    = 1'b1;
              // rearm for the next text; tables stay
              active_d      = 8'd0;
              stopped_d     = 1'b0;
              bytes_d       = 16'd0;
              best_len_d    = 16'd0;
              best_valid_d  = 1'b0;
              ovf_d         = 1'b0;
              cache_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_TRANS: begin
        st_d = ST_RUN;
        if (tr_rd_q.none || (32'(tr_rd_q.target) >= 32'(NUM_STATES))) begin
          stopped_d = 1'b1;
        end else begin
          // step to the target and read its entry
          active_d   = tr_rd_q.target;
          st_re      = 1'b1;
          st_raddr   = tgt_ext[SAW-1:0];
          from_mem_d = 1'b1;
          acc_pend_d = 1'b1;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_RUN;
      active_q      <= 8'd0;
      stopped_q     <= 1'b0;
      bytes_q       <= 16'd0;
      best_len_q    <= 16'd0;
      best_valid_q  <= 1'b0;
      ovf_q         <= 1'b0;
      cache_valid_q <= 1'b0;
      from_mem_q    <= 1'b0;
      acc_pend_q    <= 1'b0;
    end else begin
      st_q          <= st_d;
      active_q      <= active_d;
      stopped_q     <= stopped_d;
      bytes_q       <= bytes_d;
      best_len_q    <= best_len_d;
      best_valid_q  <= best_valid_d;
      ovf_q         <= ovf_d;
      cache_valid_q <= cache_valid_d;
      from_mem_q    <= from_mem_d;
      acc_pend_q    <= acc_pend_d;
    end
  end

  // Cached entry of the active state
  always_ff @(posedge clk_i) begin
    cache_q <= cache_d;
  end

  // State table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= state_mem[st_raddr];
    end
  end

  // Transition table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      trans_mem[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      tr_rd_q <= trans_mem[tr_raddr];
    end
  end

  `DFA_LM_ASSERT_NEXT(a_trans_follows, tr_re, st_q == ST_TRANS, "trans read without wait state")
  `DFA_LM_ASSERT(a_fresh_has_read, !from_mem_q || $past(st_re), "read data used without read")
  `DFA_LM_ASSERT(a_stopped_no_read, !(stopped_q && tr_re), "stopped walk read transitions")
  `DFA_LM_ASSERT(a_bytes_limit, bytes_q <= TEXT_LIMIT, "byte count past the text limit")

endmodule

>>> src/dfa_lm_out_buf.sv
// Two-entry result buffer between the walk and the master stream.
module dfa_lm_out_buf import dfa_lm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic [1:0] count_q, count_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign res_o   = slot0_q;
  assign pop     = valid_o && ready_i;
  assign count_d = count_q + {1'b0, push_i} - {1'b0, pop};

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Slots: slot0 faces the stream
  always_ff @(posedge clk_i) begin
    case ({push_i, pop})
      2'b11: begin
        if (count_q == 2'd1) begin
          slot0_q <= res_i;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= res_i;
        end
      end
      2'b10: begin
        if (count_q == 2'd0) begin
          slot0_q <= res_i;
        end else begin
          slot1_q <= res_i;
        end
      end
      2'b01: begin
        slot0_q <= slot1_q;
      end
      default: ;
    endcase
  end

endmodule

>>> src/dfa_longest_match_core.sv
// Longest accepted prefix of a byte text, found by a table-driven DFA.
// Load transactions write state entries and transition words into two
// on-chip tables; text bytes walk the machine from state 0 and the end
// transaction returns found, length and a too-long flag, then rearms the
// walk while keeping the tables. A text byte that passes the range and
// index checks reads the transition table, then the state table at the
// target, chained through the active state. A byte that fails the range or
// index check, arrives after the walk has stopped, or lies past the text
// limit reads no table. The walk stops for good on a byte out of range, a
// missing transition or an index past a table. After the end transaction,
// state 0 is read back before the next transaction is taken. Results wait
// in a two-entry buffer, so input keeps flowing while the master side
// stalls until two results are waiting; then all input stalls.
module dfa_longest_match_core import dfa_lm_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int TRANS_DEPTH = TRANS_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_index, accepts, lowest_byte, highest_byte, delta_base,
  // target_state, target_none, text_byte (from bit 0 up), zero padded
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // match_found, match_length, text_too_long (from bit 0 up), zero padded
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  in_item_t in_item;
  action_e  in_action;
  logic     res_push;
  logic     out_space;
  result_t  res_in;
  result_t  res_out;

  assign in_item   = in_item_t'(s_axis_tdata[ITEM_W-1:0]);
  assign in_action = action_e'(s_axis_tuser);

  // Table walk
  dfa_lm_walk #(
    .NUM_STATES (NUM_STATES),
    .TRANS_DEPTH(TRANS_DEPTH)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_action_i(in_action),
    .in_item_i  (in_item),
    .out_space_i(out_space),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result buffer
  dfa_lm_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_in),
    .space_o(out_space),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res_out)
  );

  assign m_axis_tdata = {{(M_TDATA_W - RES_W){1'b0}}, res_out};

endmodule
